// ===== hdl/ple_pkg.sv =====
package ple_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned ADDR_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W       = 8;
  localparam int unsigned OUT_W       = 32;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_LOCATE = 3'd4,
    CMD_PRED   = 3'd5,
    CMD_SUCC   = 3'd6,
    CMD_LENGTH = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POS   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  function automatic value_t to_store(input logic [OUT_W-1:0] raw);
    logic [63:0] ext;
    ext = {{(64 - OUT_W){raw[OUT_W-1]}}, raw};
    return ext[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] from_store(input value_t v);
    logic [63:0] ext;
    ext = {{(64 - VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
    return ext[OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/ple_ram.sv =====
module ple_ram #(
  parameter int unsigned Width     = 32,
  parameter int unsigned Depth     = 64,
  parameter int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed values held in one single-port-write,
// registered-read RAM. A request is taken when start is high and busy is low;
// its result appears on the result ports for exactly one cycle with
// result_valid_o high and cannot be held off, so the receiver must take it then.
// Clear and length query answer in the cycle after the request. Get reads one
// element. Insert and delete move the tail one element per cycle through the
// RAM. Locate, predecessor and successor scan from the head one element per
// cycle, up to the end of the list when the value is absent, and successor then
// reads the element after the hit. The single RAM read port limits all of this
// work to one element per cycle. busy is high while a request is being worked
// on, and a new request may be given in the cycle its result shows.
module positional_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] operand_value_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] result_value_o,
  output logic [7:0]  result_position_o,
  output logic [7:0]  list_length_o,
  output logic        list_empty_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_SCAN
  } state_e;

  state_e                          state_q, state_d;
  ple_pkg::cmd_e                   cmd_q, cmd_d;
  ple_pkg::addr_t                  pos_q, pos_d;
  ple_pkg::value_t                 val_q, val_d;
  ple_pkg::count_t                 cnt_q, cnt_d;
  ple_pkg::addr_t                  ptr_q, ptr_d;
  ple_pkg::count_t                 rem_q, rem_d;
  ple_pkg::addr_t                  di_q, di_d;
  logic                            dv_q, dv_d;
  logic                            first_q, first_d;
  ple_pkg::value_t                 prev_q, prev_d;
  logic                            valid_q, valid_d;
  ple_pkg::status_e                status_q, status_d;
  logic [ple_pkg::OUT_W-1:0]       rval_q, rval_d;
  logic [ple_pkg::POS_W-1:0]       rpos_q, rpos_d;

  logic                            ram_we;
  ple_pkg::addr_t                  ram_waddr;
  ple_pkg::value_t                 ram_wdata;
  logic                            ram_re;
  ple_pkg::value_t                 ram_rdata;

  logic [8:0]                      pos9;
  logic [8:0]                      len9;
  ple_pkg::addr_t                  pos_m1;
  ple_pkg::count_t                 tail_cnt;
  logic                            hit;

  ple_ram #(
    .Width (ple_pkg::VALUE_WIDTH),
    .Depth (ple_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign pos9     = {1'b0, position_i};
  assign len9     = 9'(cnt_q);
  assign pos_m1   = ple_pkg::addr_t'(position_i - 8'd1);
  assign tail_cnt = ple_pkg::count_t'(len9 - pos9 + 9'd1);
  assign hit      = (ram_rdata == val_q);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    val_d     = val_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    rem_d     = rem_q;
    di_d      = di_q;
    dv_d      = 1'b0;
    first_d   = first_q;
    prev_d    = prev_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    rval_d    = rval_q;
    rpos_d    = rpos_q;
    ram_we    = 1'b0;
    ram_waddr = di_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;

    // pipelined read, one element per cycle
    if (state_q != S_IDLE && rem_q != '0) begin
      ram_re = 1'b1;
      dv_d   = 1'b1;
      di_d   = ptr_q;
      rem_d  = rem_q - 1'b1;
      if (state_q == S_MOVE && cmd_q == ple_pkg::CMD_INSERT) begin
        ptr_d = ptr_q - 1'b1;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = ple_pkg::cmd_e'(command_i);
          pos_d    = pos_m1;
          val_d    = ple_pkg::to_store(operand_value_i);
          rval_d   = '0;
          rpos_d   = '0;
          status_d = ple_pkg::ST_OK;
          first_d  = 1'b0;
          case (ple_pkg::cmd_e'(command_i))
            ple_pkg::CMD_CLEAR: begin
              cnt_d   = '0;
              valid_d = 1'b1;
            end
            ple_pkg::CMD_INSERT: begin
              if (position_i == '0 || pos9 > len9 + 9'd1) begin
                status_d = ple_pkg::ST_BAD_POS;
                valid_d  = 1'b1;
              end else if (len9 == 9'(ple_pkg::CAPACITY)) begin
                status_d = ple_pkg::ST_FULL;
                valid_d  = 1'b1;
              end else begin
                state_d = S_MOVE;
                ptr_d   = ple_pkg::addr_t'(cnt_q - 1'b1);
                rem_d   = tail_cnt;
              end
            end
            ple_pkg::CMD_DELETE, ple_pkg::CMD_GET: begin
              if (position_i == '0 || pos9 > len9) begin
                status_d = ple_pkg::ST_BAD_POS;
                valid_d  = 1'b1;
              end else begin
                state_d = S_MOVE;
                ptr_d   = pos_m1;
                first_d = 1'b1;
                if (ple_pkg::cmd_e'(command_i) == ple_pkg::CMD_DELETE) begin
                  rem_d = tail_cnt;
                end else begin
                  rem_d = ple_pkg::count_t'(1);
                end
              end
            end
            ple_pkg::CMD_LOCATE, ple_pkg::CMD_PRED, ple_pkg::CMD_SUCC: begin
              if (cnt_q == '0) begin
                status_d = ple_pkg::ST_NOT_FOUND;
                valid_d  = 1'b1;
              end else begin
                state_d = S_SCAN;
                ptr_d   = '0;
                rem_d   = cnt_q;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      S_MOVE: begin
        if (dv_q) begin
          if (first_q) begin
            rval_d  = ple_pkg::from_store(ram_rdata);
            first_d = 1'b0;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (cmd_q == ple_pkg::CMD_INSERT) begin
              ram_waddr = di_q + 1'b1;
            end else begin
              ram_waddr = di_q - 1'b1;
            end
          end
        end else if (rem_q == '0) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          case (cmd_q)
            ple_pkg::CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pos_q;
              ram_wdata = val_q;
              cnt_d     = cnt_q + 1'b1;
            end
            ple_pkg::CMD_DELETE: begin
              cnt_d = cnt_q - 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (dv_q) begin
          prev_d = ram_rdata;
          if (hit) begin
            case (cmd_q)
              ple_pkg::CMD_LOCATE: begin
                rpos_d  = ple_pkg::POS_W'(di_q) + 1'b1;
                valid_d = 1'b1;
                state_d = S_IDLE;
              end
              ple_pkg::CMD_PRED: begin
                if (di_q == '0) begin
                  status_d = ple_pkg::ST_NOT_FOUND;
                end else begin
                  rval_d = ple_pkg::from_store(prev_q);
                end
                valid_d = 1'b1;
                state_d = S_IDLE;
              end
              default: begin
                if (ple_pkg::count_t'(di_q) + 1'b1 >= cnt_q) begin
                  status_d = ple_pkg::ST_NOT_FOUND;
                  valid_d  = 1'b1;
                  state_d  = S_IDLE;
                end else begin
                  // fetch the neighbour as a single read
                  state_d = S_MOVE;
                  ptr_d   = di_q + 1'b1;
                  rem_d   = ple_pkg::count_t'(1);
                  first_d = 1'b1;
                  dv_d    = 1'b0;
                end
              end
            endcase
          end else if (rem_q == '0) begin
            status_d = ple_pkg::ST_NOT_FOUND;
            valid_d  = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      dv_q     <= 1'b0;
      first_q  <= 1'b0;
      valid_q  <= 1'b0;
      cmd_q    <= ple_pkg::CMD_CLEAR;
      status_q <= ple_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      dv_q     <= dv_d;
      first_q  <= first_d;
      valid_q  <= valid_d;
      cmd_q    <= cmd_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    ptr_q  <= ptr_d;
    di_q   <= di_d;
    prev_q <= prev_d;
    rval_q <= rval_d;
    rpos_q <= rpos_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = valid_q;
  assign status_o          = status_q;
  assign result_value_o    = rval_q;
  assign result_position_o = rpos_q;
  assign list_length_o     = 8'(cnt_q);
  assign list_empty_o      = (cnt_q == '0);

endmodule

// ===== hdl/ple_checker.sv =====
module ple_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [7:0]  result_position_o,
  input logic [7:0]  list_length_o,
  input logic        list_empty_o
);

  // every request either answers at once or keeps the block busy
  a_request_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("request neither answered nor in progress");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (list_empty_o == (list_length_o == 8'd0)))
    else $error("empty flag disagrees with length");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (list_length_o <= 8'(ple_pkg::CAPACITY)))
    else $error("length beyond capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ple_pkg::ST_FULL)
      |-> (list_length_o == 8'(ple_pkg::CAPACITY)))
    else $error("full status on a list that is not full");

  a_failed_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ple_pkg::ST_OK) |-> (result_position_o == 8'd0))
    else $error("position reported on a failed request");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_valid_o    (result_valid_o),
  .status_o          (status_o),
  .result_position_o (result_position_o),
  .list_length_o     (list_length_o),
  .list_empty_o      (list_empty_o)
);
